// File: rtl/pnslt_pkg.sv
// Package for the per-node sequence loss tracker: status codes, entry record
// and the control record passed along the cell chain. No dependencies.
`default_nettype none
package pnslt_pkg;

	localparam logic [2:0] ST_FIRST    = 3'd0;
	localparam logic [2:0] ST_INORDER  = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_REORDER  = 3'd3;
	localparam logic [2:0] ST_RESYNC   = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;
	localparam logic [2:0] ST_CLEARED  = 3'd6;

	localparam logic signed [11:0] RSSI_MIN = -12'sd2048;

	// Per-node record held by one cell.
	typedef struct packed {
		logic              used;
		logic              seq_valid;
		logic [15:0]       node;
		logic [15:0]       last_seq;
		logic [31:0]       received;
		logic [31:0]       lost;
		logic [31:0]       dups;
		logic [31:0]       reorders;
		logic [31:0]       resyncs;
		logic signed [11:0] best_rssi;
		logic signed [11:0] worst_rssi;
		logic [23:0]       farthest;
	} entry_t;

	// Operations broadcast to every cell.
	typedef struct packed {
		logic        clear;
		logic        write;
		logic        alloc;
		logic [15:0] node;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/pnslt_cell.sv
// One table cell of the tracker: holds one node entry and passes its
// record to the next cell during a lookup. Depends on pnslt_pkg.
`default_nettype none
module pnslt_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  pnslt_pkg::cell_ctl_t ctl,
	input  wire                 sel,
	input  pnslt_pkg::entry_t   wr_entry,
	input  pnslt_pkg::entry_t   prev,
	input  wire                 shift,
	output pnslt_pkg::entry_t   entry
);

	pnslt_pkg::entry_t entry_q;

	// A clear empties the cell; a shift during a lookup rotates the chain; a write updates the selected cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q           <= '0;
			entry_q.best_rssi <= pnslt_pkg::RSSI_MIN;
		end else if (ctl.clear) begin
			entry_q           <= '0;
			entry_q.best_rssi <= pnslt_pkg::RSSI_MIN;
		end else if (shift) begin
			entry_q <= prev;
		end else if (ctl.write && sel) begin
			entry_q <= wr_entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire

// File: rtl/pnslt_update.sv
// Update arithmetic for one matched entry: classifies the sequence step and
// forms the new record and status. Depends on pnslt_pkg.
`default_nettype none
module pnslt_update (
	input  wire                 clk,
	input  pnslt_pkg::entry_t   cur,
	input  wire [15:0]          node,
	input  wire [15:0]          seq,
	input  wire signed [11:0]   rssi,
	input  wire [23:0]          distance,
	input  wire [14:0]          resync_gap,
	input  wire                 load,
	output pnslt_pkg::entry_t   nxt,
	output logic [2:0]          status,
	output logic                rx_inc,
	output logic                lost_dec,
	output logic [31:0]         lost_add
);

	logic [15:0] d;
	pnslt_pkg::entry_t n;
	logic [2:0] st;
	logic rx, dec;
	logic [31:0] add;

	// Classify the step and update counters.
	always_comb begin
		d   = seq - cur.last_seq;
		n   = cur;
		n.used = 1'b1;
		n.node = node;
		rx  = 1'b1;
		dec = 1'b0;
		add = '0;
		if (!cur.seq_valid) begin
			n.seq_valid = 1'b1;
			n.last_seq  = seq;
			st = pnslt_pkg::ST_FIRST;
		end else if (d == 16'd0) begin
			n.dups = cur.dups + 32'd1;
			rx = 1'b0;
			st = pnslt_pkg::ST_DUP;
		end else if (d[15]) begin
			n.reorders = cur.reorders + 32'd1;
			dec = (cur.lost != 32'd0);
			if (dec) n.lost = cur.lost - 32'd1;
			st = pnslt_pkg::ST_REORDER;
		end else if (d[14:0] > resync_gap) begin
			n.resyncs  = cur.resyncs + 32'd1;
			n.last_seq = seq;
			st = pnslt_pkg::ST_RESYNC;
		end else begin
			add        = {16'd0, d - 16'd1};
			n.lost     = cur.lost + add;
			n.last_seq = seq;
			st = pnslt_pkg::ST_INORDER;
		end
		if (rx) n.received = cur.received + 32'd1;
		if (rssi > cur.best_rssi) n.best_rssi = rssi;
		if (cur.worst_rssi == 12'sd0 || rssi < cur.worst_rssi) n.worst_rssi = rssi;
		if (distance > cur.farthest) n.farthest = distance;
	end

	// Register the result so the write happens in the next cycle.
	always_ff @(posedge clk) begin
		if (load) begin
			nxt      <= n;
			status   <= st;
			rx_inc   <= rx;
			lost_dec <= dec;
			lost_add <= add;
		end
	end

endmodule
`default_nettype wire

// File: rtl/per_node_sequence_loss_tracker.sv
// Top level of the per-node sequence loss tracker: cell chain, update unit,
// sequencer and output register. Depends on pnslt_pkg, pnslt_cell, pnslt_update.
//
// Usage: report words enter on s_axis (tuser = opcode, tdata = node_id, seq,
// rssi, snr, distance, now_ms). One result word per report leaves on m_axis.
// cfg_we/cfg_wdata write resync_gap; the user must write it only while the block is idle (not enforced here).
// A report rotates the whole cell chain once, comparing the head cell's node
// each cycle, then passes through an update state, a write state and an
// output state that loads the output register. A clear skips the scan,
// update and write states and goes straight to the output state.
// One report is worked on at a time; s_axis_tready is low meanwhile.
// The result sits in an output register; when the receiver stalls, the next
// report is still taken and worked on, and waits to write its result until
// the register is free.
// Reset empties the table, zeroes the totals and sets resync_gap to 256.
`default_nettype none
module per_node_sequence_loss_tracker #(
	parameter int MAX_NODES = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire  [14:0]  cfg_wdata,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: node_id[15:0], seq[31:16], rssi[43:32], snr[51:44],
	// distance[75:52], now_ms[123:76], zero[127:124]
	input  wire  [127:0] s_axis_tdata,
	// tuser: opcode
	input  wire          s_axis_tuser,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// tdata: status[2:0], slot[6:3], received_count[38:7], lost_count[70:39],
	// duplicate_count[102:71], reorder_count[134:103], resync_count[166:135],
	// best_rssi[178:167], worst_rssi[190:179], node_farthest[214:191],
	// total_received[246:215], total_lost[278:247], zero[279]
	output logic [279:0] m_axis_tdata
);

	localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_UPD    = 5'b00100,
		S_WRITE  = 5'b01000,
		S_OUT    = 5'b10000
	} state_t;

	state_t state_q;
	logic [14:0] gap_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;
	logic [IW-1:0] hit_q;
	logic found_q;
	logic [31:0] sum_rx_q, sum_lost_q;
	logic [15:0] node_q, seq_q;
	logic signed [11:0] rssi_q;
	logic [23:0] dist_q;
	logic [2:0] res_st_q;
	logic res_full_q;
	logic res_clear_q;
	logic [IW-1:0] slot_q;

	pnslt_pkg::entry_t ent [MAX_NODES];
	pnslt_pkg::entry_t upd_entry;
	pnslt_pkg::entry_t fresh;
	pnslt_pkg::entry_t cur;
	pnslt_pkg::cell_ctl_t ctl;
	logic [2:0] upd_st;
	logic upd_rx, upd_dec;
	logic [31:0] upd_add;
	logic shift;
	logic [IW-1:0] wr_idx;
	logic take;
	logic head_hit;

	assign take  = s_axis_tvalid && s_axis_tready;
	assign shift = (state_q == S_SCAN);
	assign s_axis_tready = (state_q == S_IDLE);
	assign head_hit = ent[0].used && (ent[0].node == node_q);

	// A new record when the node is not yet in the table.
	always_comb begin
		fresh           = '0;
		fresh.best_rssi = pnslt_pkg::RSSI_MIN;
	end
	assign cur    = found_q ? ent[hit_q] : fresh;
	assign wr_idx = found_q ? hit_q : count_q[IW-1:0];

	always_comb begin
		ctl.clear = take && s_axis_tuser;
		ctl.write = (state_q == S_WRITE) && !res_full_q;
		ctl.alloc = !found_q;
		ctl.node  = node_q;
	end

	// The chain of cells, rotating as a ring during the scan.
	for (genvar g = 0; g < MAX_NODES; g++) begin : g_cell
		pnslt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.sel      (wr_idx == IW'(g)),
			.wr_entry (upd_entry),
			.prev     (ent[(g + 1) % MAX_NODES]),
			.shift    (shift),
			.entry    (ent[g])
		);
	end

	pnslt_update u_upd (
		.clk        (clk),
		.cur        (cur),
		.node       (node_q),
		.seq        (seq_q),
		.rssi       (rssi_q),
		.distance   (dist_q),
		.resync_gap (gap_q),
		.load       (state_q == S_UPD),
		.nxt        (upd_entry),
		.status     (upd_st),
		.rx_inc     (upd_rx),
		.lost_dec   (upd_dec),
		.lost_add   (upd_add)
	);

	// Register holding resync_gap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) gap_q <= 15'd256;
		else if (cfg_we) gap_q <= cfg_wdata;
	end

	// Sequencer: scan the ring, update, write back, present; a clear goes straight to present.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			hit_q       <= '0;
			found_q     <= 1'b0;
			sum_rx_q    <= '0;
			sum_lost_q  <= '0;
			res_full_q  <= 1'b0;
			res_clear_q <= 1'b0;
			res_st_q    <= pnslt_pkg::ST_FIRST;
			slot_q      <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != S_OUT)
				m_axis_tvalid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						found_q <= 1'b0;
						scan_q  <= '0;
						res_full_q <= 1'b0;
						if (s_axis_tuser) begin
							count_q     <= '0;
							sum_rx_q    <= '0;
							sum_lost_q  <= '0;
							res_clear_q <= 1'b1;
							state_q     <= S_OUT;
						end else begin
							res_clear_q <= 1'b0;
							state_q     <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// The head cell holds the entry whose index equals the scan count.
					if (!found_q && head_hit) begin
						found_q <= 1'b1;
						hit_q   <= scan_q[IW-1:0];
					end
					scan_q <= scan_q + CW'(1);
					if (scan_q == CW'(MAX_NODES - 1)) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (!found_q && !head_hit && count_q == CW'(MAX_NODES))
						res_full_q <= 1'b1;
					if (!found_q && head_hit) begin
						found_q <= 1'b1;
						hit_q   <= '0;
					end else begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (!res_full_q) begin
						slot_q   <= wr_idx;
						res_st_q <= upd_st;
						if (!found_q) count_q <= count_q + CW'(1);
						sum_rx_q <= sum_rx_q + {31'd0, upd_rx};
						sum_lost_q <= sum_lost_q + upd_add - {31'd0, upd_dec};
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the input word.
	always_ff @(posedge clk) begin
		if (take) begin
			node_q <= s_axis_tdata[15:0];
			seq_q  <= s_axis_tdata[31:16];
			rssi_q <= s_axis_tdata[43:32];
			dist_q <= s_axis_tdata[75:52];
		end
	end

	// Output word, loaded when the result is presented.
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
			m_axis_tdata <= '0;
			if (res_clear_q) begin
				m_axis_tdata[2:0] <= pnslt_pkg::ST_CLEARED;
			end else if (res_full_q) begin
				m_axis_tdata[2:0]     <= pnslt_pkg::ST_FULL;
				m_axis_tdata[246:215] <= sum_rx_q;
				m_axis_tdata[278:247] <= sum_lost_q;
			end else begin
				m_axis_tdata[2:0]     <= res_st_q;
				m_axis_tdata[6:3]     <= 4'(slot_q);
				m_axis_tdata[38:7]    <= upd_entry.received;
				m_axis_tdata[70:39]   <= upd_entry.lost;
				m_axis_tdata[102:71]  <= upd_entry.dups;
				m_axis_tdata[134:103] <= upd_entry.reorders;
				m_axis_tdata[166:135] <= upd_entry.resyncs;
				m_axis_tdata[178:167] <= upd_entry.best_rssi;
				m_axis_tdata[190:179] <= upd_entry.worst_rssi;
				m_axis_tdata[214:191] <= upd_entry.farthest;
				m_axis_tdata[246:215] <= sum_rx_q;
				m_axis_tdata[278:247] <= sum_lost_q;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/pnslt_checker.sv
// Port-level checker for the per-node sequence loss tracker, bound to the
// top level. Depends only on the top-level ports.
`default_nettype none
module pnslt_checker (
	input wire         clk,
	input wire         arst_n,
	input wire         s_axis_tvalid,
	input wire         s_axis_tready,
	input wire         m_axis_tvalid,
	input wire         m_axis_tready,
	input wire [279:0] m_axis_tdata
);

	// A stalled result word holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// No new report is taken in the cycle after one is taken.
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("back to back accept");

	// Status code never exceeds the cleared code.
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7)
		else $error("bad status");

	// A cleared result carries zero totals.
	a_clr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == 3'd6 |-> m_axis_tdata[279:3] == '0)
		else $error("clear result not zero");

endmodule

bind per_node_sequence_loss_tracker pnslt_checker u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
